// File: src/tdc_pkg.sv
// Shared widths, constants and word types of the tensor dimension coalescer.
`timescale 1ns / 1ps

package tdc_pkg;

	// Field widths fixed by the interface.
	localparam int EXT_W     = 32;
	localparam int STRIDE_W  = 64;
	localparam int OUT_EXT_W = 63;
	localparam int CFG_W     = 2;

	// Number of stride lanes carried on the ports.
	localparam int LANES = 3;

	// Default and reset values.
	localparam int              DEF_MAX_TENSORS = 3;
	localparam logic [CFG_W-1:0] TIU_RESET       = 2'd2;

	// Depths of the queue between front and back, and of the result queue.
	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 2;

	// Saturation value of a merged extent.
	localparam logic [OUT_EXT_W-1:0] EXTENT_MAX = {OUT_EXT_W{1'b1}};

	typedef logic [LANES-1:0][STRIDE_W-1:0] stride_vec_t;

	// One incoming dimension word as taken from the ports.
	typedef struct packed {
		logic [EXT_W-1:0] extent;
		stride_vec_t      stride;
		logic             last;
	} in_word_t;

	// One classified word: the dimension plus its exact extent-times-stride products.
	typedef struct packed {
		logic [EXT_W-1:0] extent;
		stride_vec_t      stride;
		stride_vec_t      prod;
		logic [LANES-1:0] fits;
		logic             last;
	} mid_word_t;

	// One coalesced result word.
	typedef struct packed {
		logic [OUT_EXT_W-1:0] extent;
		stride_vec_t          stride;
		logic                 last;
	} out_word_t;

	// Status of the back part, watched at the top level.
	typedef struct packed {
		logic second;
		logic pend_valid;
	} back_status_t;

endpackage

// File: src/tdc_fifo.sv
// Small register-based first-in first-out queue with one write and one read per cycle.
`timescale 1ns / 1ps

module tdc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	// Occupancy flags come straight from the registered count.
	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: src/tdc_front.sv
// Front part: accepts dimension words and forms the exact extent-times-stride products.
`timescale 1ns / 1ps

module tdc_front import tdc_pkg::*; #(
	parameter int MAX_TENSORS = DEF_MAX_TENSORS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  in_word,
	input  logic      in_push,
	output logic      in_full,
	output mid_word_t mid_word,
	output logic      mid_push,
	input  logic      mid_full
);

	logic                        adv;
	logic                        v_s1;
	logic                        v_s2;
	logic [EXT_W-1:0]            ext_s1;
	logic                        last_s1;
	stride_vec_t                 stride_s1;
	logic [LANES-1:0][63:0]      plo_s1;
	logic [LANES-1:0][64:0]      phi_s1;
	stride_vec_t                 stride_d;
	logic [LANES-1:0][63:0]      plo_d;
	logic [LANES-1:0][64:0]      phi_d;
	stride_vec_t                 prod_d;
	logic [LANES-1:0]            fits_d;
	mid_word_t                   mid_s2;

	// Both stages move together whenever the second stage can drain or is empty.
	assign adv      = !v_s2 || !mid_full;
	assign in_full  = !adv;
	assign mid_push = v_s2 && !mid_full;
	assign mid_word = mid_s2;

	// Per lane: two partial products in the first stage, recombined in the second.
	genvar g;
	for (g = 0; g < LANES; g++) begin : g_lane
		if (g < MAX_TENSORS) begin : g_used
			logic signed [64:0] phi_l;
			logic        [96:0] sum_l;

			// Extent times the low and the signed high half of the stride.
			assign plo_d[g]    = 64'(in_word.extent) * 64'(in_word.stride[g][31:0]);
			assign phi_l       = 65'($signed({1'b0, in_word.extent})) *
				65'($signed(in_word.stride[g][63:32]));
			assign phi_d[g]    = phi_l;
			assign stride_d[g] = in_word.stride[g];

			// Full product; it matches a stride only if it fits in 64 signed bits.
			assign sum_l     = {phi_s1[g], 32'b0} + {33'b0, plo_s1[g]};
			assign prod_d[g] = sum_l[63:0];
			assign fits_d[g] = (sum_l[96:63] == '0) || (sum_l[96:63] == '1);
		end else begin : g_unused
			assign plo_d[g]    = '0;
			assign phi_d[g]    = '0;
			assign stride_d[g] = '0;
			assign prod_d[g]   = '0;
			assign fits_d[g]   = 1'b1;
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_push;
			v_s2 <= v_s1;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			ext_s1          <= in_word.extent;
			last_s1         <= in_word.last;
			stride_s1       <= stride_d;
			plo_s1          <= plo_d;
			phi_s1          <= phi_d;
			mid_s2.extent   <= ext_s1;
			mid_s2.stride   <= stride_s1;
			mid_s2.prod     <= prod_d;
			mid_s2.fits     <= fits_d;
			mid_s2.last     <= last_s1;
		end
	end

endmodule

// File: src/tdc_back.sv
// Back part: merges classified words into the held dimension and emits result words.
`timescale 1ns / 1ps

module tdc_back import tdc_pkg::*; #(
	parameter int MAX_TENSORS = DEF_MAX_TENSORS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [LANES-1:0] act,
	input  mid_word_t        head,
	input  logic             head_empty,
	output logic             head_pop,
	output out_word_t        out_word,
	output logic             out_push,
	input  logic             out_full,
	output back_status_t     status
);

	logic [OUT_EXT_W-1:0] pend_ext_q;
	stride_vec_t          pend_str;
	logic                 pend_valid_q;
	logic                 second_q;

	logic                 pend_one;
	logic                 in_one;
	logic [LANES-1:0]     match;
	logic                 merge;
	logic [OUT_EXT_W-1:0] in_ext;
	logic [63:0]          mul_lo;
	logic [62:0]          mul_hi;
	logic [64:0]          mul_sum;
	logic [OUT_EXT_W-1:0] mul_sat;

	logic                 nx_valid;
	logic [OUT_EXT_W-1:0] nx_ext;
	stride_vec_t          nx_str;
	logic                 nx_second;
	logic                 emit;
	logic [OUT_EXT_W-1:0] emit_ext;
	stride_vec_t          emit_str;
	logic                 emit_last;
	logic                 fire;

	assign status.second     = second_q;
	assign status.pend_valid = pend_valid_q;

	// Merge test against the held dimension.
	assign pend_one = (pend_ext_q == OUT_EXT_W'(1));
	assign in_one   = (head.extent == EXT_W'(1));
	assign in_ext   = OUT_EXT_W'(head.extent);

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			match[i] = !act[i] || (head.fits[i] && (head.prod[i] == pend_str[i]));
		end
	end

	assign merge = pend_one || in_one || (&match);

	// Saturating product of the held extent and the incoming one, in two halves.
	assign mul_lo  = 64'(pend_ext_q[31:0]) * 64'(head.extent);
	assign mul_hi  = 63'(pend_ext_q[62:32]) * 63'(head.extent);
	assign mul_sum = {2'b0, mul_hi[30:0], 32'b0} + {1'b0, mul_lo};
	assign mul_sat = ((mul_hi[62:31] != '0) || (mul_sum[64:63] != '0)) ?
		EXTENT_MAX : mul_sum[62:0];

	// Next held dimension and the word to emit, if any.
	always_comb begin
		nx_valid  = pend_valid_q;
		nx_ext    = pend_ext_q;
		nx_str    = pend_str;
		nx_second = 1'b0;
		emit      = 1'b0;
		emit_ext  = pend_ext_q;
		emit_str  = pend_str;
		emit_last = 1'b0;
		priority if (second_q) begin
			// Second word of a split item: the freshly held dimension closes the shape.
			emit      = 1'b1;
			emit_last = 1'b1;
			nx_valid  = 1'b0;
			nx_ext    = '0;
			nx_str    = '0;
		end else if (!pend_valid_q) begin
			// Nothing held yet: take the incoming dimension.
			nx_valid = 1'b1;
			nx_ext   = in_ext;
			nx_str   = head.stride;
			if (head.last) begin
				emit      = 1'b1;
				emit_ext  = in_ext;
				emit_str  = head.stride;
				emit_last = 1'b1;
				nx_valid  = 1'b0;
				nx_ext    = '0;
				nx_str    = '0;
			end
		end else if (merge) begin
			// Fold the incoming dimension into the held one.
			nx_ext = mul_sat;
			nx_str = in_one ? pend_str : head.stride;
			if (head.last) begin
				emit      = 1'b1;
				emit_ext  = mul_sat;
				emit_str  = in_one ? pend_str : head.stride;
				emit_last = 1'b1;
				nx_valid  = 1'b0;
				nx_ext    = '0;
				nx_str    = '0;
			end
		end else begin
			// No merge: emit the held dimension and hold the incoming one.
			emit      = 1'b1;
			nx_ext    = in_ext;
			nx_str    = head.stride;
			nx_second = head.last;
		end
	end

	// A step goes ahead when a word is waiting and any result word has room.
	assign fire     = !head_empty && !(emit && out_full);
	assign head_pop = fire && !nx_second;
	assign out_push = fire && emit;

	always_comb begin
		out_word.extent = emit_ext;
		out_word.last   = emit_last;
		for (int i = 0; i < LANES; i++) begin
			out_word.stride[i] = act[i] ? emit_str[i] : '0;
		end
	end

	// Control and held extent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			second_q     <= 1'b0;
			pend_ext_q   <= '0;
		end else if (fire) begin
			pend_valid_q <= nx_valid;
			second_q     <= nx_second;
			pend_ext_q   <= nx_ext;
		end
	end

	// Held strides exist only for the lanes that can be in use.
	genvar g;
	for (g = 0; g < LANES; g++) begin : g_str
		if (g < MAX_TENSORS) begin : g_used
			logic [STRIDE_W-1:0] str_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					str_q <= '0;
				end else if (fire) begin
					str_q <= nx_str[g];
				end
			end

			assign pend_str[g] = str_q;
		end else begin : g_unused
			assign pend_str[g] = '0;
		end
	end

endmodule

// File: src/tensor_dim_coalescer_unit.sv
// Top level of the tensor dimension coalescer: configuration, front, queues and back.
//
// Channel   Direction  Handshake             Word
// input     in         push / full           dim_extent, in_stride_*, last_dim
// result    out        empty / pop           out_extent, out_stride_*, out_last
// config    in         cfg_write             cfg_data (tensors in use)
//
// One dimension word is taken per cycle while the front is not held by a full queue; the
// result it causes is registered in the first and second product stages of the front, the
// queue between the parts and the result queue.
// A word that closes the shape after a failed merge yields two result words and holds
// the back until both are pushed; results leave at one word per cycle while pop is held.
// Reset is asynchronous: nothing is held and tensors in use returns to two.
// Either side may stall freely; the queues between the parts absorb the difference.
`timescale 1ns / 1ps

module tensor_dim_coalescer_unit import tdc_pkg::*; #(
	parameter int MAX_TENSORS = DEF_MAX_TENSORS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic        [CFG_W-1:0]     cfg_data,
	input  logic                        push,
	output logic                        full,
	input  logic        [EXT_W-1:0]     dim_extent,
	input  logic signed [STRIDE_W-1:0]  in_stride_first,
	input  logic signed [STRIDE_W-1:0]  in_stride_second,
	input  logic signed [STRIDE_W-1:0]  in_stride_third,
	input  logic                        last_dim,
	output logic                        empty,
	input  logic                        pop,
	output logic        [OUT_EXT_W-1:0] out_extent,
	output logic signed [STRIDE_W-1:0]  out_stride_first,
	output logic signed [STRIDE_W-1:0]  out_stride_second,
	output logic signed [STRIDE_W-1:0]  out_stride_third,
	output logic                        out_last
);

	localparam logic [CFG_W-1:0] MAX_CFG = CFG_W'(MAX_TENSORS);

	logic [CFG_W-1:0] tiu_q;
	logic [CFG_W-1:0] n_eff;
	logic [LANES-1:0] act;
	in_word_t         in_word;
	mid_word_t        mid_wr;
	mid_word_t        mid_rd;
	logic             mid_push;
	logic             mid_full;
	logic             mid_pop;
	logic             mid_empty;
	out_word_t        out_wr;
	out_word_t        out_rd;
	logic             out_push;
	logic             out_full;
	back_status_t     status;

	// Tensors-in-use register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiu_q <= TIU_RESET;
		end else if (cfg_write) begin
			tiu_q <= cfg_data;
		end
	end

	// Clamp the register into range and form the lane mask.
	always_comb begin
		if (tiu_q == '0) begin
			n_eff = CFG_W'(1);
		end else if (tiu_q > MAX_CFG) begin
			n_eff = MAX_CFG;
		end else begin
			n_eff = tiu_q;
		end
		for (int i = 0; i < LANES; i++) begin
			act[i] = (CFG_W'(i) < n_eff);
		end
	end

	// Input word from the ports.
	assign in_word.extent    = dim_extent;
	assign in_word.stride[0] = in_stride_first;
	assign in_word.stride[1] = in_stride_second;
	assign in_word.stride[2] = in_stride_third;
	assign in_word.last      = last_dim;

	tdc_front #(
		.MAX_TENSORS (MAX_TENSORS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.in_push  (push),
		.in_full  (full),
		.mid_word (mid_wr),
		.mid_push (mid_push),
		.mid_full (mid_full)
	);

	// Queue between front and back.
	tdc_fifo #(
		.WIDTH ($bits(mid_word_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wr),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rd),
		.empty  (mid_empty)
	);

	tdc_back #(
		.MAX_TENSORS (MAX_TENSORS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.act        (act),
		.head       (mid_rd),
		.head_empty (mid_empty),
		.head_pop   (mid_pop),
		.out_word   (out_wr),
		.out_push   (out_push),
		.out_full   (out_full),
		.status     (status)
	);

	// Result queue.
	tdc_fifo #(
		.WIDTH ($bits(out_word_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_wr),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rd),
		.empty  (empty)
	);

	// Result word to the ports.
	assign out_extent        = out_rd.extent;
	assign out_stride_first  = out_rd.stride[0];
	assign out_stride_second = out_rd.stride[1];
	assign out_stride_third  = out_rd.stride[2];
	assign out_last          = out_rd.last;

	// The back never offers a result word to a full result queue.
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result word pushed into a full queue");

	// A split item always has a dimension held for its second word.
	a_second_held: assert property (@(posedge clk) disable iff (!arst_n)
		status.second |-> status.pend_valid)
		else $error("second result phase with nothing held");

	// Retiring a word that closes the shape leaves nothing held.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(mid_pop && mid_rd.last) |=> !status.pend_valid)
		else $error("dimension still held after the last word");

endmodule

// File: test/tb.sv
// Self-checking testbench for the tensor dimension coalescer: directed shapes, then random ones.
`timescale 1ns / 1ps

module tb import tdc_pkg::*;;

	localparam int MAX_TENSORS    = DEF_MAX_TENSORS;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	// One coalesced dimension as it should leave the block.
	typedef struct packed {
		logic [OUT_EXT_W-1:0] extent;
		logic [STRIDE_W-1:0]  s_first;
		logic [STRIDE_W-1:0]  s_second;
		logic [STRIDE_W-1:0]  s_third;
		logic                 last_flag;
	} coalesced_dim_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_write;
	logic        [CFG_W-1:0]     cfg_data;
	logic                        push;
	logic                        full;
	logic        [EXT_W-1:0]     dim_extent;
	logic signed [STRIDE_W-1:0]  in_stride_first;
	logic signed [STRIDE_W-1:0]  in_stride_second;
	logic signed [STRIDE_W-1:0]  in_stride_third;
	logic                        last_dim;
	logic                        empty;
	logic                        pop;
	logic        [OUT_EXT_W-1:0] out_extent;
	logic signed [STRIDE_W-1:0]  out_stride_first;
	logic signed [STRIDE_W-1:0]  out_stride_second;
	logic signed [STRIDE_W-1:0]  out_stride_third;
	logic                        out_last;

	// Expected results, oldest first, and the mismatch count.
	coalesced_dim_t expected_dims[$];
	int             failures;
	int             idle_count;
	bit             tx_quiet;
	bit             rx_quiet;

	// Shadow of the coalescing state and of the tensors-in-use register.
	logic [OUT_EXT_W-1:0] held_extent;
	stride_vec_t          held_stride;
	bit                   held_valid;
	logic [CFG_W-1:0]     tensors_live;

	tensor_dim_coalescer_unit #(
		.MAX_TENSORS(MAX_TENSORS)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_data         (cfg_data),
		.push             (push),
		.full             (full),
		.dim_extent       (dim_extent),
		.in_stride_first  (in_stride_first),
		.in_stride_second (in_stride_second),
		.in_stride_third  (in_stride_third),
		.last_dim         (last_dim),
		.empty            (empty),
		.pop              (pop),
		.out_extent       (out_extent),
		.out_stride_first (out_stride_first),
		.out_stride_second(out_stride_second),
		.out_stride_third (out_stride_third),
		.out_last         (out_last)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Number of tensors whose strides take part, with out-of-range settings clamped.
	function automatic int lanes_checked();
		int n;
		n = (tensors_live == 0) ? 1 : int'(tensors_live);
		if (n > MAX_TENSORS)
			n = MAX_TENSORS;
		return n;
	endfunction

	// Exact test that extent times stride equals the held stride, with no wrapping.
	function automatic bit stride_fits(logic [EXT_W-1:0] ext, logic [STRIDE_W-1:0] st,
			logic [STRIDE_W-1:0] target);
		logic signed [96:0] prod;
		prod = 97'($signed({1'b0, ext})) * 97'($signed(st));
		return prod == 97'($signed(target));
	endfunction

	// Queue the held dimension as an expected result.
	task automatic emit_held(input bit last_flag, input int n);
		coalesced_dim_t d;
		d.extent    = held_extent;
		d.s_first   = held_stride[0];
		d.s_second  = (n > 1) ? held_stride[1] : '0;
		d.s_third   = (n > 2) ? held_stride[2] : '0;
		d.last_flag = last_flag;
		expected_dims.push_back(d);
	endtask

	// Advance the shadow state by one accepted dimension word.
	task automatic coalesce_dim(input logic [EXT_W-1:0] ext, input stride_vec_t st,
			input bit last_flag);
		int         n;
		bit         merge;
		logic [95:0] prod;
		n = lanes_checked();
		if (!held_valid) begin
			held_extent = OUT_EXT_W'(ext);
			held_stride = st;
			held_valid  = 1'b1;
		end else begin
			merge = (held_extent == 1) || (ext == 1);
			if (!merge) begin
				merge = 1'b1;
				for (int t = 0; t < n; t++)
					if (!stride_fits(ext, st[t], held_stride[t]))
						merge = 1'b0;
			end
			if (merge) begin
				if (ext != 1)
					held_stride = st;
				prod = 96'(held_extent) * 96'(ext);
				held_extent = (prod > 96'(EXTENT_MAX)) ? EXTENT_MAX : prod[OUT_EXT_W-1:0];
			end else begin
				emit_held(1'b0, n);
				held_extent = OUT_EXT_W'(ext);
				held_stride = st;
			end
		end
		if (last_flag) begin
			emit_held(1'b1, n);
			held_valid  = 1'b0;
			held_extent = '0;
			held_stride = '0;
		end
	endtask

	// Send one dimension word after a random gap and update the shadow once it is taken.
	task automatic send_dim(input logic [EXT_W-1:0] ext, input stride_vec_t st,
			input bit last_flag);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push             <= 1'b1;
		dim_extent       <= ext;
		in_stride_first  <= st[0];
		in_stride_second <= st[1];
		in_stride_third  <= st[2];
		last_dim         <= last_flag;
		do @(posedge clk); while (full);
		coalesce_dim(ext, st, last_flag);
	endtask

	// Stop sending, wait for every expected word and let the pipeline settle.
	task automatic drain_results();
		push <= 1'b0;
		while (expected_dims.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the tensors-in-use register while the block is idle.
	task automatic set_tensors(input logic [CFG_W-1:0] value);
		drain_results();
		cfg_write <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		tensors_live = value;
	endtask

	function automatic logic [STRIDE_W-1:0] rand_wide();
		return {$urandom, $urandom};
	endfunction

	function automatic stride_vec_t rand_strides();
		stride_vec_t st;
		for (int t = 0; t < LANES; t++)
			st[t] = rand_wide();
		return st;
	endfunction

	function automatic stride_vec_t make_strides(logic [STRIDE_W-1:0] a,
			logic [STRIDE_W-1:0] b, logic [STRIDE_W-1:0] c);
		stride_vec_t st;
		st[0] = a;
		st[1] = b;
		st[2] = c;
		return st;
	endfunction

	// Lone dimensions closing the shape, under the reset value of the register.
	task automatic test_single_dim();
		send_dim(32'd5, rand_strides(), 1'b1);
		send_dim(32'hFFFF_FFFF, rand_strides(), 1'b1);
	endtask

	// Contiguous dimensions fold into one; the third tensor is not in use and is ignored.
	task automatic test_contiguous_merge();
		send_dim(32'd2, make_strides(64'd12, 64'd24, 64'd1), 1'b0);
		send_dim(32'd3, make_strides(64'd4, 64'd8, 64'd5), 1'b0);
		send_dim(32'd4, make_strides(64'd1, 64'd2, 64'd9), 1'b1);
	endtask

	// Extent 1 on either side always merges; an incoming 1 keeps the held strides.
	task automatic test_unit_extents();
		send_dim(32'd1, rand_strides(), 1'b0);
		send_dim(32'd7, rand_strides(), 1'b0);
		send_dim(32'd1, rand_strides(), 1'b0);
		send_dim(32'd3, rand_strides(), 1'b1);
	endtask

	// A failed merge on the closing word yields two result words in turn.
	task automatic test_stride_break();
		send_dim(32'd2, make_strides(64'd100, 64'd6, 64'd0), 1'b0);
		send_dim(32'd3, make_strides(64'd1, 64'd2, 64'd0), 1'b1);
		send_dim(32'd2, make_strides(64'd6, -64'sd6, 64'd0), 1'b0);
		send_dim(32'd3, make_strides(64'd2, 64'd2, 64'd0), 1'b0);
		send_dim(32'd5, make_strides(64'd1, 64'd1, 64'd0), 1'b1);
	endtask

	// Stride extremes, products beyond 64 bits, zero extents and extent saturation.
	task automatic test_extremes();
		set_tensors(2'd3);
		send_dim(32'd3, make_strides(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
			64'd0), 1'b0);
		send_dim(32'd2, make_strides(64'hC000_0000_0000_0000, 64'd1317624576693539401,
			64'd0), 1'b0);
		send_dim(32'd7, make_strides(64'h2492_4924_9249_2492, 64'd188232082384791343,
			64'd0), 1'b1);
		// The wrapped product would match here, the exact one does not.
		send_dim(32'd4, make_strides(64'hC000_0000_0000_0000, 64'hC000_0000_0000_0000,
			64'hC000_0000_0000_0000), 1'b0);
		send_dim(32'hFFFF_FFFF, make_strides(64'h4000_0000_0000_0000,
			64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000), 1'b1);
		send_dim(32'd3, '0, 1'b0);
		send_dim(32'd0, rand_strides(), 1'b0);
		send_dim(32'd5, rand_strides(), 1'b1);
		send_dim(32'hFFFF_FFFF, '0, 1'b0);
		send_dim(32'hFFFF_FFFF, '0, 1'b0);
		send_dim(32'd3, '0, 1'b1);
	endtask

	// With one tensor in use the others carry zero; a setting of zero behaves as one.
	task automatic test_unused_tensors();
		set_tensors(2'd1);
		send_dim(32'd4, make_strides(64'd2, rand_wide(), rand_wide()), 1'b0);
		send_dim(32'd2, make_strides(64'd1, rand_wide(), rand_wide()), 1'b1);
		set_tensors(2'd0);
		send_dim(32'd4, make_strides(-64'sd8, rand_wide(), rand_wide()), 1'b0);
		send_dim(32'd2, make_strides(-64'sd4, rand_wide(), rand_wide()), 1'b1);
	endtask

	function automatic logic [EXT_W-1:0] pick_extent();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return 32'd1;
		if (r < 16)
			return 32'd0;
		if (r < 22)
			return $urandom;
		if (r < 24)
			return 32'hFFFF_FFFF;
		return $urandom_range(2, 9);
	endfunction

	function automatic logic [STRIDE_W-1:0] pick_base_stride();
		int          r;
		logic [STRIDE_W-1:0] s;
		r = $urandom_range(0, 99);
		if (r < 10)
			return rand_wide();
		if (r < 13)
			return 64'h8000_0000_0000_0000;
		if (r < 16)
			return 64'h7FFF_FFFF_FFFF_FFFF;
		s = 64'($urandom_range(0, 5));
		if ($urandom_range(0, 3) == 0)
			s = -s;
		return s;
	endfunction

	// Random shapes, mostly built contiguous from the inside out, with breaks and noise.
	task automatic test_random_shapes(input logic [CFG_W-1:0] setting, input int items);
		int                 sent;
		int                 ndims;
		bit                 noise;
		logic [EXT_W-1:0]   ext_arr [8];
		stride_vec_t        st_arr [8];
		set_tensors(setting);
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 19) == 0)
				tx_quiet = !tx_quiet;
			ndims = $urandom_range(1, 6);
			noise = ($urandom_range(0, 9) == 0);
			for (int i = 0; i < ndims; i++) begin
				ext_arr[i] = noise ? $urandom : pick_extent();
				for (int t = 0; t < LANES; t++) begin
					if (noise)
						st_arr[i][t] = rand_wide();
					else if (i == 0 || $urandom_range(0, 9) >= 8)
						st_arr[i][t] = pick_base_stride();
					else
						st_arr[i][t] = 64'(ext_arr[i-1]) * st_arr[i-1][t];
				end
			end
			// Outermost first; the innermost closes the shape.
			for (int i = ndims - 1; i >= 0; i--) begin
				send_dim(ext_arr[i], st_arr[i], i == 0);
				sent++;
			end
		end
	endtask

	function automatic void compare_field(string name, logic [STRIDE_W-1:0] exp_val,
			logic [STRIDE_W-1:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s expected %h, got %h", $time, name, exp_val, act_val);
			failures++;
		end
	endfunction

	// Compare one accepted result word with the oldest expectation.
	task automatic check_dim();
		coalesced_dim_t d;
		if (expected_dims.size() == 0) begin
			$display("%0t: unexpected word, expected none, got extent %h last %b",
				$time, out_extent, out_last);
			failures++;
		end else begin
			d = expected_dims.pop_front();
			compare_field("out_extent", 64'(d.extent), 64'(out_extent));
			compare_field("out_stride_first", d.s_first, out_stride_first);
			compare_field("out_stride_second", d.s_second, out_stride_second);
			compare_field("out_stride_third", d.s_third, out_stride_third);
			compare_field("out_last", 64'(d.last_flag), 64'(out_last));
		end
	endtask

	// Result side: random stalls, then take and check each word.
	initial begin
		int stall;
		pop <= 1'b0;
		rx_quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_quiet ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			check_dim();
			if ($urandom_range(0, 39) == 0)
				rx_quiet = !rx_quiet;
		end
	end

	// Watchdog on cycles in which no word moves on either side.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n) begin
			idle_count = 0;
		end else begin
			idle_count++;
			if (idle_count >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Reset, the tests in turn, then the verdict.
	initial begin
		tx_quiet         = 1'b0;
		tensors_live     = TIU_RESET;
		held_extent      = '0;
		held_stride      = '0;
		held_valid       = 1'b0;
		arst_n           <= 1'b0;
		cfg_write        <= 1'b0;
		cfg_data         <= '0;
		push             <= 1'b0;
		dim_extent       <= '0;
		in_stride_first  <= '0;
		in_stride_second <= '0;
		in_stride_third  <= '0;
		last_dim         <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_dim();
		test_contiguous_merge();
		test_unit_extents();
		test_stride_break();
		test_extremes();
		test_unused_tensors();
		test_random_shapes(2'd2, 450);
		test_random_shapes(2'd3, 450);
		test_random_shapes(2'd1, 450);
		test_random_shapes(2'd0, 450);
		drain_results();

		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
